@@ sv/fxp_pkg.sv @@
package fxp_pkg;

  localparam int unsigned LenW   = 24;
  localparam int unsigned FifoDp = 4;
  localparam int unsigned PtrW   = $clog2(FifoDp);
  localparam int unsigned CntW   = $clog2(FifoDp + 1);

  // result kinds
  localparam logic [2:0] KIND_NAME = 3'd0;
  localparam logic [2:0] KIND_BASE = 3'd1;
  localparam logic [2:0] KIND_QUAL = 3'd2;
  localparam logic [2:0] KIND_REC  = 3'd3;
  localparam logic [2:0] KIND_EOS  = 3'd4;
  localparam logic [2:0] KIND_ERR  = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_FORMAT  = 3'd1;
  localparam logic [2:0] ERR_INCOMPL = 3'd2;
  localparam logic [2:0] ERR_BADCHAR = 3'd3;
  localparam logic [2:0] ERR_EMPTY   = 3'd4;
  localparam logic [2:0] ERR_QCOUNT  = 3'd5;
  localparam logic [2:0] ERR_TOOLONG = 3'd6;

  localparam logic [7:0] ChGt    = 8'h3E; // '>'
  localparam logic [7:0] ChAt    = 8'h40; // '@'
  localparam logic [7:0] ChPlus  = 8'h2B; // '+'
  localparam logic [7:0] ChSlash = 8'h2F; // '/'
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] QualLo  = 8'd33;
  localparam logic [7:0] QualHi  = 8'd127;

  typedef enum logic [2:0] {
    PH_DETECT,
    PH_NAME,
    PH_SEQ,
    PH_COMMENT,
    PH_QUAL,
    PH_SEEK,
    PH_HALT
  } phase_e;

  typedef struct packed {
    logic [2:0]      kind;
    logic [7:0]      value;
    logic [LenW-1:0] rec_len;
    logic            fastq;
    logic [2:0]      err;
    logic            last;
  } res_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] value,
                                  logic [LenW-1:0] rec_len, logic fastq,
                                  logic [2:0] err);
    res_t r;
    r.kind    = kind;
    r.value   = value;
    r.rec_len = rec_len;
    r.fastq   = fastq;
    r.err     = err;
    r.last    = 1'b0;
    return r;
  endfunction

  // A0 C1 G2 T3, any other letter 4; case folded
  function automatic logic [7:0] base_code(logic [7:0] b);
    logic [7:0] u;
    u = b & 8'hDF;
    case (u)
      8'h41:   return 8'd0;
      8'h43:   return 8'd1;
      8'h47:   return 8'd2;
      8'h54:   return 8'd3;
      default: return 8'd4;
    endcase
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'd0) || (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

endpackage

@@ sv/fastx_record_parser.sv @@
// FASTA/FASTQ record parser. One file byte (or an end-of-input mark) is
// taken per cycle on the input channel; each byte yields zero, one or two
// result words, which queue in a four-word output buffer. With the output
// side always ready the block sustains one byte per clock while the buffer
// has room; a byte that yields two words (a held name pair, record end plus
// end of stream) fills the buffer faster than it drains, and in_ready_o
// drops only when the output buffer cannot take two more words. The first
// '>' or '@' fixes the format for the whole stream. After an error word or
// the end-of-stream word the parser halts: further bytes are still accepted
// but yield nothing until reset.
module fastx_record_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_input_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             kind_o,
  output logic [7:0]             value_o,
  output logic [fxp_pkg::LenW-1:0] record_length_o,
  output logic                   is_fastq_o,
  output logic [2:0]             error_code_o,
  output logic                   last_o
);
  import fxp_pkg::*;

  phase_e          phase_q, phase_d;
  logic            fastq_q, fastq_d;
  logic [7:0]      held0_q, held0_d, held1_q, held1_d;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic            space_q, space_d;
  logic [1:0]      name_len_q, name_len_d;
  logic [LenW-1:0] base_cnt_q, base_cnt_d;
  logic [LenW-1:0] qual_cnt_q, qual_cnt_d;

  res_t            fifo_q [FifoDp];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  res_t            r0, r1;
  logic [1:0]      n_res;
  logic            start_rec;
  logic            take, pop;

  logic [7:0] b;
  logic       eoi, is_lf, is_crlf, letter, base_full, qual_ok, qual_over, strip;

  assign b         = data_byte_i;
  assign eoi       = end_of_input_i;
  assign is_lf     = (b == ChLf);
  assign is_crlf   = (b == ChCr) || is_lf;
  assign letter    = is_letter(b);
  assign base_full = (base_cnt_q == {LenW{1'b1}});
  assign qual_ok   = (b >= QualLo) && (b <= QualHi);
  // quality count never exceeds base count, so >= means this one overflows
  assign qual_over = (qual_cnt_q >= base_cnt_q);
  assign strip     = !space_q && (name_len_q == 2'd3) && (held_cnt_q == 2'd2) &&
                     (held0_q == ChSlash) && ((held1_q == ChOne) || (held1_q == ChTwo));

  assign pop        = out_valid_o && out_ready_i;
  assign in_ready_o = (cnt_q <= CntW'(FifoDp - 2)) ||
                      ((cnt_q == CntW'(FifoDp - 1)) && pop);
  assign take       = in_valid_i && in_ready_o;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_DETECT: begin
        if (eoi || is_lf) phase_d = PH_HALT;
        else if (b == ChGt || b == ChAt) phase_d = PH_NAME;
      end
      PH_NAME: begin
        if (eoi) phase_d = PH_HALT;
        else if (is_lf) phase_d = PH_SEQ;
      end
      PH_SEQ: begin
        if (eoi) phase_d = PH_HALT;
        else if (!fastq_q && b == ChGt) phase_d = PH_NAME;
        else if (fastq_q && b == ChPlus) begin
          phase_d = (base_cnt_q == '0) ? PH_HALT : PH_COMMENT;
        end else if (!is_crlf && (!letter || base_full)) phase_d = PH_HALT;
      end
      PH_COMMENT: begin
        if (eoi) phase_d = PH_HALT;
        else if (is_lf) phase_d = PH_QUAL;
      end
      PH_QUAL: begin
        if (eoi || is_lf) begin
          phase_d = (eoi || qual_cnt_q != base_cnt_q) ? PH_HALT : PH_SEEK;
        end else if (qual_ok && qual_over) phase_d = PH_HALT;
      end
      PH_SEEK: begin
        if (eoi) phase_d = PH_HALT;
        else if (b == (fastq_q ? ChAt : ChGt)) phase_d = PH_NAME;
      end
      PH_HALT: phase_d = PH_HALT;
      default: phase_d = PH_HALT;
    endcase
  end

  // results and datapath updates
  always_comb begin
    r0         = mk_res(KIND_NAME, 8'd0, '0, fastq_q, ERR_NONE);
    r1         = r0;
    n_res      = 2'd0;
    start_rec  = 1'b0;
    fastq_d    = fastq_q;
    held0_d    = held0_q;
    held1_d    = held1_q;
    held_cnt_d = held_cnt_q;
    space_d    = space_q;
    name_len_d = name_len_q;
    base_cnt_d = base_cnt_q;
    qual_cnt_d = qual_cnt_q;
    case (phase_q)
      PH_DETECT: begin
        if (eoi || is_lf) begin
          r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_FORMAT); n_res = 2'd1;
        end else if (b == ChGt || b == ChAt) begin
          fastq_d   = (b == ChAt);
          start_rec = 1'b1;
        end
      end
      PH_NAME: begin
        if (eoi) begin
          r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_INCOMPL); n_res = 2'd1;
        end else if (is_lf || (!space_q && is_blank(b))) begin
          // flush the held pair unless it is a read-pair suffix
          if (!(is_lf && strip)) begin
            r0    = mk_res(KIND_NAME, held0_q, '0, fastq_q, ERR_NONE);
            r1    = mk_res(KIND_NAME, held1_q, '0, fastq_q, ERR_NONE);
            n_res = held_cnt_q;
          end
          held_cnt_d = 2'd0;
          if (!is_lf) space_d = 1'b1;
        end else if (!space_q) begin
          if (held_cnt_q == 2'd2) begin
            r0      = mk_res(KIND_NAME, held0_q, '0, fastq_q, ERR_NONE);
            n_res   = 2'd1;
            held0_d = held1_q;
            held1_d = b;
          end else if (held_cnt_q == 2'd1) begin
            held1_d    = b;
            held_cnt_d = 2'd2;
          end else begin
            held0_d    = b;
            held_cnt_d = 2'd1;
          end
          if (name_len_q != 2'd3) name_len_d = name_len_q + 2'd1;
        end
      end
      PH_SEQ: begin
        if (eoi) begin
          if (fastq_q) begin
            r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_INCOMPL); n_res = 2'd1;
          end else begin
            r0    = mk_res(KIND_REC, 8'd0, base_cnt_q, fastq_q, ERR_NONE);
            r1    = mk_res(KIND_EOS, 8'd0, '0, fastq_q, ERR_NONE);
            n_res = 2'd2;
          end
        end else if (!fastq_q && b == ChGt) begin
          r0        = mk_res(KIND_REC, 8'd0, base_cnt_q, fastq_q, ERR_NONE);
          n_res     = 2'd1;
          start_rec = 1'b1;
        end else if (fastq_q && b == ChPlus) begin
          if (base_cnt_q == '0) begin
            r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_EMPTY); n_res = 2'd1;
          end
        end else if (!is_crlf) begin
          n_res = 2'd1;
          if (!letter) r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_BADCHAR);
          else if (base_full) r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_TOOLONG);
          else begin
            r0         = mk_res(KIND_BASE, base_code(b), '0, fastq_q, ERR_NONE);
            base_cnt_d = base_cnt_q + LenW'(1);
          end
        end
      end
      PH_COMMENT: begin
        if (eoi) begin
          r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_INCOMPL); n_res = 2'd1;
        end
      end
      PH_QUAL: begin
        if (eoi || is_lf) begin
          if (qual_cnt_q != base_cnt_q) begin
            r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_QCOUNT); n_res = 2'd1;
          end else begin
            r0    = mk_res(KIND_REC, 8'd0, base_cnt_q, fastq_q, ERR_NONE);
            r1    = mk_res(KIND_EOS, 8'd0, '0, fastq_q, ERR_NONE);
            n_res = eoi ? 2'd2 : 2'd1;
          end
        end else if (qual_ok) begin
          qual_cnt_d = qual_cnt_q + LenW'(1);
          n_res      = 2'd1;
          if (qual_over) r0 = mk_res(KIND_ERR, 8'd0, '0, fastq_q, ERR_QCOUNT);
          else r0 = mk_res(KIND_QUAL, b, '0, fastq_q, ERR_NONE);
        end
      end
      PH_SEEK: begin
        if (eoi) begin
          r0 = mk_res(KIND_EOS, 8'd0, '0, fastq_q, ERR_NONE); n_res = 2'd1;
        end else if (b == (fastq_q ? ChAt : ChGt)) begin
          start_rec = 1'b1;
        end
      end
      PH_HALT: n_res = 2'd0;
      default: n_res = 2'd0;
    endcase
    if (start_rec) begin
      held0_d    = 8'd0;
      held1_d    = 8'd0;
      held_cnt_d = 2'd0;
      space_d    = 1'b0;
      name_len_d = 2'd0;
      base_cnt_d = '0;
      qual_cnt_d = '0;
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DETECT;
      fastq_q    <= 1'b0;
      held0_q    <= 8'd0;
      held1_q    <= 8'd0;
      held_cnt_q <= 2'd0;
      space_q    <= 1'b0;
      name_len_q <= 2'd0;
      base_cnt_q <= '0;
      qual_cnt_q <= '0;
    end else if (take) begin
      phase_q    <= phase_d;
      fastq_q    <= fastq_d;
      held0_q    <= held0_d;
      held1_q    <= held1_d;
      held_cnt_q <= held_cnt_d;
      space_q    <= space_d;
      name_len_q <= name_len_d;
      base_cnt_q <= base_cnt_d;
      qual_cnt_q <= qual_cnt_d;
    end
  end

  // output buffer: up to two words pushed, one popped per cycle
  logic [1:0]      n_push;
  logic [CntW-1:0] cnt_d;
  assign n_push = take ? n_res : 2'd0;
  assign cnt_d  = cnt_q + CntW'(n_push) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) fifo_q[wr_ptr_q] <= r0;
    if (n_push == 2'd2) fifo_q[wr_ptr_q + PtrW'(1)] <= r1;
  end

  res_t head;
  assign head            = fifo_q[rd_ptr_q];
  assign out_valid_o     = (cnt_q != '0);
  assign kind_o          = head.kind;
  assign value_o         = head.value;
  assign record_length_o = head.rec_len;
  assign is_fastq_o      = head.fastq;
  assign error_code_o    = head.err;
  assign last_o          = head.last;

endmodule

@@ sv/fxp_chk.sv @@
module fxp_chk (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [2:0]               kind_o,
  input logic [7:0]               value_o,
  input logic [fxp_pkg::LenW-1:0] record_length_o,
  input logic                     is_fastq_o,
  input logic [2:0]               error_code_o,
  input logic                     last_o
);
  import fxp_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(value_o) && $stable(record_length_o) && $stable(is_fastq_o) &&
    $stable(error_code_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // error and end-of-stream words always close their byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ERR || kind_o == KIND_EOS) |-> last_o)
    else $error("terminal word without last");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KIND_ERR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match kind");

  // only record end carries a length
  a_len_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_REC |-> record_length_o == '0)
    else $error("length on a non record-end word");

endmodule

bind fastx_record_parser fxp_chk u_fxp_chk (.*);

@@ test/fastx_record_parser_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the parser, runs its own model of the record
// parser on every accepted input word and compares each accepted result
// word with the oldest one awaited.
module fastx_record_parser_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     end_of_input_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [2:0]               kind_i,
  input  logic [7:0]               value_i,
  input  logic [fxp_pkg::LenW-1:0] record_length_i,
  input  logic                     is_fastq_i,
  input  logic [2:0]               error_code_i,
  input  logic                     last_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);
  import fxp_pkg::*;

  localparam logic [LenW:0] MaxBases = {1'b0, {LenW{1'b1}}};

  phase_e        parse_q;
  logic          fastq_q;
  logic [7:0]    held_q [2];
  logic [1:0]    held_n_q;
  logic          blank_seen_q;
  logic [1:0]    name_len_q;
  logic [LenW:0] base_cnt_q;
  logic [LenW:0] qual_cnt_q;

  res_t awaited_words [$];
  res_t step_words [$];

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd0) || (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic [7:0] code_of(input logic [7:0] b);
    case (b)
      "A", "a": return 8'd0;
      "C", "c": return 8'd1;
      "G", "g": return 8'd2;
      "T", "t": return 8'd3;
      default:  return 8'd4;
    endcase
  endfunction

  task automatic emit(input logic [2:0] k, input logic [7:0] v,
                      input logic [LenW-1:0] len, input logic [2:0] e);
    res_t r;
    r.kind    = k;
    r.value   = v;
    r.rec_len = len;
    r.fastq   = fastq_q;
    r.err     = e;
    r.last    = 1'b0;
    step_words.push_back(r);
  endtask

  task automatic halt_with(input logic [2:0] code);
    parse_q = PH_HALT;
    emit(KIND_ERR, 8'd0, '0, code);
  endtask

  task automatic open_record();
    parse_q      = PH_NAME;
    held_n_q     = 2'd0;
    held_q[0]    = 8'd0;
    held_q[1]    = 8'd0;
    blank_seen_q = 1'b0;
    name_len_q   = 2'd0;
    base_cnt_q   = '0;
    qual_cnt_q   = '0;
  endtask

  task automatic flush_held();
    int unsigned i;
    for (i = 0; i < held_n_q; i++) emit(KIND_NAME, held_q[i[0]], '0, ERR_NONE);
    held_n_q = 2'd0;
  endtask

  task automatic close_record();
    emit(KIND_REC, 8'd0, base_cnt_q[LenW-1:0], ERR_NONE);
  endtask

  task automatic take_letter(input logic [7:0] b);
    if (!is_alpha(b)) begin
      halt_with(ERR_BADCHAR);
    end else if (base_cnt_q >= MaxBases) begin
      halt_with(ERR_TOOLONG);
    end else begin
      base_cnt_q++;
      emit(KIND_BASE, code_of(b), '0, ERR_NONE);
    end
  endtask

  task automatic parse_word(input logic [7:0] b, input logic eoi);
    int unsigned i;
    res_t r;
    step_words.delete();
    case (parse_q)
      PH_DETECT: begin
        if (eoi || b == ChLf) begin
          halt_with(ERR_FORMAT);
        end else if (b == ChGt || b == ChAt) begin
          fastq_q = (b == ChAt);
          open_record();
        end
      end
      PH_NAME: begin
        if (eoi) begin
          halt_with(ERR_INCOMPL);
        end else if (b == ChLf) begin
          // read-pair suffix is dropped only on a blank-free line of 3+ bytes
          if (!blank_seen_q && name_len_q == 2'd3 && held_n_q == 2'd2 &&
              held_q[0] == ChSlash && (held_q[1] == ChOne || held_q[1] == ChTwo))
            held_n_q = 2'd0;
          else
            flush_held();
          parse_q = PH_SEQ;
        end else if (!blank_seen_q) begin
          if (is_ws(b)) begin
            flush_held();
            blank_seen_q = 1'b1;
          end else begin
            if (held_n_q == 2'd2) begin
              emit(KIND_NAME, held_q[0], '0, ERR_NONE);
              held_q[0] = held_q[1];
              held_q[1] = b;
            end else begin
              held_q[held_n_q[0]] = b;
              held_n_q++;
            end
            if (name_len_q != 2'd3) name_len_q++;
          end
        end
      end
      PH_SEQ: begin
        if (!fastq_q) begin
          if (eoi) begin
            close_record();
            emit(KIND_EOS, 8'd0, '0, ERR_NONE);
            parse_q = PH_HALT;
          end else if (b == ChGt) begin
            close_record();
            open_record();
          end else if (b != ChCr && b != ChLf) begin
            take_letter(b);
          end
        end else begin
          if (eoi) begin
            halt_with(ERR_INCOMPL);
          end else if (b == ChPlus) begin
            if (base_cnt_q == '0) halt_with(ERR_EMPTY);
            else parse_q = PH_COMMENT;
          end else if (b != ChCr && b != ChLf) begin
            take_letter(b);
          end
        end
      end
      PH_COMMENT: begin
        if (eoi) halt_with(ERR_INCOMPL);
        else if (b == ChLf) parse_q = PH_QUAL;
      end
      PH_QUAL: begin
        if (eoi || b == ChLf) begin
          if (qual_cnt_q != base_cnt_q) begin
            halt_with(ERR_QCOUNT);
          end else begin
            close_record();
            if (eoi) begin
              emit(KIND_EOS, 8'd0, '0, ERR_NONE);
              parse_q = PH_HALT;
            end else begin
              parse_q = PH_SEEK;
            end
          end
        end else if (b >= QualLo && b <= QualHi) begin
          qual_cnt_q++;
          if (qual_cnt_q > base_cnt_q) halt_with(ERR_QCOUNT);
          else emit(KIND_QUAL, b, '0, ERR_NONE);
        end
      end
      PH_SEEK: begin
        if (eoi) begin
          emit(KIND_EOS, 8'd0, '0, ERR_NONE);
          parse_q = PH_HALT;
        end else if (b == (fastq_q ? ChAt : ChGt)) begin
          open_record();
        end
      end
      default: parse_q = PH_HALT;
    endcase
    for (i = 0; i < step_words.size(); i++) begin
      r = step_words[i];
      r.last = (i == step_words.size() - 1);
      awaited_words.push_back(r);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_word();
    res_t want;
    if (awaited_words.size() == 0) begin
      $error("result word with none awaited: kind %0d value %0d", kind_i, value_i);
      fail_count_o++;
    end else begin
      want = awaited_words.pop_front();
      check_field("kind", want.kind, kind_i);
      check_field("value", want.value, value_i);
      check_field("record_length", want.rec_len, record_length_i);
      check_field("is_fastq", want.fastq, is_fastq_i);
      check_field("error_code", want.err, error_code_i);
      check_field("last", want.last, last_i);
      checked_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_words.delete();
      open_record();
      parse_q   = PH_DETECT;
      fastq_q   = 1'b0;
      pending_o = 0;
    end else begin
      // a result leaving now always stems from an earlier input word
      if (out_valid_i && out_ready_i) check_word();
      if (in_valid_i && in_ready_i) parse_word(data_byte_i, end_of_input_i);
      pending_o = awaited_words.size();
    end
  end

endmodule

@@ test/fastx_record_parser_tb.sv @@
`timescale 1ns / 1ps

module fastx_record_parser_tb;
  import fxp_pkg::*;

  localparam int unsigned ItemTarget  = 1700;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleCycles = 40;

  typedef enum int {
    END_DETECT,
    END_NAME_EOI,
    END_BADCHAR,
    END_BODY_EOI,
    END_SEQ_EOI,
    END_PLUS_EOI,
    END_EMPTY,
    END_QUAL_OVER,
    END_QUAL_UNDER_LF,
    END_QUAL_UNDER_EOI,
    END_QUAL_EOI,
    END_SEEK_EOI
  } ending_e;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      data_byte = 8'h00;
  logic            end_of_input = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [2:0]      kind;
  logic [7:0]      value;
  logic [LenW-1:0] record_length;
  logic            is_fastq;
  logic [2:0]      error_code;
  logic            last;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned bytes_sent;
  int unsigned records_sent;
  int unsigned cycles;
  bit          sender_burst;
  bit          recv_burst;
  bit          hold_req;
  bit          fastq_run;
  ending_e     ending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fastx_record_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .end_of_input_i  (end_of_input),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .value_o         (value),
    .record_length_o (record_length),
    .is_fastq_o      (is_fastq),
    .error_code_o    (error_code),
    .last_o          (last)
  );

  fastx_record_parser_checker chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .data_byte_i     (data_byte),
    .end_of_input_i  (end_of_input),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .kind_i          (kind),
    .value_i         (value),
    .record_length_i (record_length),
    .is_fastq_i      (is_fastq),
    .error_code_i    (error_code),
    .last_i          (last),
    .fail_count_o    (mismatches),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still up, so a following word can keep it high.
  task automatic send_word(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(b, 1'b0);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_eoi();
    logic [7:0] junk;
    junk = 8'($urandom);
    send_word(junk, 1'b1);
  endtask

  // input idle until every awaited word is out
  task automatic drain_pause();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] k;
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 4))
        0:       k = "A";
        1:       k = "C";
        2:       k = "G";
        3:       k = "T";
        default: k = "N";
      endcase
    end else begin
      k = 8'("A" + $urandom_range(0, 25));
    end
    if ($urandom_range(0, 1)) k = k | 8'h20;
    return k;
  endfunction

  function automatic logic [7:0] rand_name_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == 8'd0 || b == 8'd32 || (b >= 8'd9 && b <= 8'd13));
    return b;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd9;
      2:       return 8'd11;
      3:       return 8'd12;
      4:       return ChCr;
      default: return 8'd32;
    endcase
  endfunction

  function automatic logic [7:0] rand_junk_nolf();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ChLf);
    return b;
  endfunction

  function automatic logic [7:0] rand_bad_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == ChCr ||
           b == ChLf || b == ChGt || b == ChPlus);
    return b;
  endfunction

  task automatic send_line_break();
    if ($urandom_range(0, 1)) send_byte(ChCr);
    send_byte(ChLf);
  endtask

  // header text after the marker, up to and including LF
  task automatic send_name_line();
    int unsigned n, m, i;
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) send_byte(rand_name_byte());
    case ($urandom_range(0, 3))
      1: begin
        send_byte(ChSlash);
        send_byte($urandom_range(0, 1) ? ChOne : ChTwo);
      end
      2: begin
        send_byte(rand_blank());
        m = $urandom_range(0, 4);
        for (i = 0; i < m; i++) send_byte(rand_junk_nolf());
      end
      3: begin
        // suffix followed by a blank must be kept
        send_byte(ChSlash);
        send_byte(ChOne);
        send_byte(rand_blank());
        send_byte(rand_name_byte());
      end
      default: ;
    endcase
    send_byte(ChLf);
  endtask

  task automatic send_bases(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(0, 7) == 0) send_line_break();
      send_byte(rand_letter());
    end
    send_line_break();
  endtask

  task automatic send_quals(input int unsigned n);
    int unsigned i;
    logic [7:0] b;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        do b = 8'($urandom); while (b == ChLf || (b >= QualLo && b <= QualHi));
        send_byte(b);
      end
      send_byte(8'($urandom_range(QualLo, QualHi)));
    end
  endtask

  // '@' header, n bases, '+' line; leaves the parser on the quality line
  task automatic fastq_to_quals(input int unsigned n);
    int unsigned m, i;
    send_byte(ChAt);
    send_name_line();
    send_bases(n);
    send_byte(ChPlus);
    m = $urandom_range(0, 4);
    for (i = 0; i < m; i++) send_byte(rand_junk_nolf());
    send_byte(ChLf);
  endtask

  task automatic send_fastq_record();
    int unsigned n, m, i;
    logic [7:0] b;
    n = $urandom_range(1, 16);
    fastq_to_quals(n);
    send_quals(n);
    send_byte(ChLf);
    m = $urandom_range(0, 3);
    for (i = 0; i < m; i++) begin
      do b = 8'($urandom); while (b == ChAt);
      send_byte(b);
    end
  endtask

  task automatic send_ending();
    int unsigned n;
    n = $urandom_range(1, 8);
    case (ending)
      END_NAME_EOI: begin
        send_byte(fastq_run ? ChAt : ChGt);
        send_byte(rand_name_byte());
        send_eoi();
      end
      END_BADCHAR: begin
        send_byte(fastq_run ? ChAt : ChGt);
        send_name_line();
        send_bases(n);
        send_byte(rand_bad_byte());
      end
      END_BODY_EOI: begin
        send_byte(ChGt);
        send_name_line();
        send_bases($urandom_range(0, 6));
        send_eoi();
      end
      END_SEQ_EOI: begin
        send_byte(ChAt);
        send_name_line();
        send_bases(n);
        send_eoi();
      end
      END_PLUS_EOI: begin
        send_byte(ChAt);
        send_name_line();
        send_bases(n);
        send_byte(ChPlus);
        send_byte(rand_junk_nolf());
        send_eoi();
      end
      END_EMPTY: begin
        send_byte(ChAt);
        send_name_line();
        if ($urandom_range(0, 1)) send_line_break();
        send_byte(ChPlus);
      end
      END_QUAL_OVER: begin
        fastq_to_quals(n);
        send_quals(n + 1);
      end
      END_QUAL_UNDER_LF: begin
        fastq_to_quals(n);
        send_quals($urandom_range(0, n - 1));
        send_byte(ChLf);
      end
      END_QUAL_UNDER_EOI: begin
        fastq_to_quals(n);
        send_quals($urandom_range(0, n - 1));
        send_eoi();
      end
      END_QUAL_EOI: begin
        fastq_to_quals(n);
        send_quals(n);
        send_eoi();
      end
      default: send_eoi();
    endcase
  endtask

  initial begin
    int unsigned i;
    logic [8:0] w;
    logic [7:0] b;
    fastq_run = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 15) == 0) begin
      ending = END_DETECT;
    end else if (fastq_run) begin
      case ($urandom_range(0, 9))
        0:       ending = END_NAME_EOI;
        1:       ending = END_BADCHAR;
        2:       ending = END_SEQ_EOI;
        3:       ending = END_PLUS_EOI;
        4:       ending = END_EMPTY;
        5:       ending = END_QUAL_OVER;
        6:       ending = END_QUAL_UNDER_LF;
        7:       ending = END_QUAL_UNDER_EOI;
        8:       ending = END_QUAL_EOI;
        default: ending = END_SEEK_EOI;
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0:       ending = END_NAME_EOI;
        1:       ending = END_BADCHAR;
        default: ending = END_BODY_EOI;
      endcase
    end

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // bytes before the first marker are skipped
    send_byte(8'h00);
    send_byte(8'hFF);
    do b = 8'($urandom); while (b == ChLf || b == ChGt || b == ChAt);
    send_byte(b);

    if (ending == END_DETECT) begin
      if ($urandom_range(0, 1)) send_byte(ChLf);
      else send_eoi();
    end else begin
      if (fastq_run) begin
        send_text("@a/1\nACgtn");
        send_byte(ChCr);
        send_text("\n+z\n!");
        send_byte(QualHi);
        send_byte(8'h80);
        send_byte(8'h20);
        send_text("~IJ\n");
      end else begin
        // dropped suffix, blank-cut name, empty record, short "/2" kept
        send_text(">a/1\nACgtNz");
        send_byte(ChCr);
        send_text("\n>ab c\n>/2\n");
      end
      drain_pause();

      while (bytes_sent < ItemTarget) begin
        if (records_sent >= 20 && records_sent < 28)
          sender_burst = 1'b1;
        else if ($urandom_range(0, 3) == 0)
          sender_burst = ~sender_burst;
        if (records_sent == 20) hold_req = 1'b1;
        if (records_sent == 35) drain_pause();
        if (fastq_run) begin
          send_fastq_record();
        end else begin
          send_byte(ChGt);
          send_name_line();
          send_bases($urandom_range(0, 24));
        end
        records_sent++;
      end
      send_ending();
    end

    // parser is halted now; these words must yield nothing
    for (i = 0; i < 16; i++) begin
      w = 9'($urandom);
      send_word(w[7:0], w[8]);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);

    $display("Ran a %s stream: %0d random records, %0d input words, closed by %s",
             fastq_run ? "FASTQ" : "FASTA", records_sent, bytes_sent, ending.name());
    $display("%0d result words compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // output side: random hold-off per word, one long stall on request
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldCycles;
      end else begin
        if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
        gap = recv_burst ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles", cycles);
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
sv/fxp_pkg.sv
sv/fastx_record_parser.sv
sv/fxp_chk.sv
test/fastx_record_parser_checker.sv
test/fastx_record_parser_tb.sv
